FILE: rtl/x86c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86c_pkg
// Shared types, codes and decode helpers of the 16-bit x86 subset core.
// ----------------------------------------------------------------------------
package x86c_pkg;

  // Memory geometry
  localparam int MemAddrBits = 16;
  localparam int MemDepth    = 2 ** MemAddrBits;
  typedef logic [MemAddrBits-1:0] maddr_t;

  // Flag bit positions
  localparam int FlagCf = 0;
  localparam int FlagPf = 2;
  localparam int FlagAf = 4;
  localparam int FlagZf = 6;
  localparam int FlagSf = 7;
  localparam int FlagOf = 11;

  // Register numbers
  localparam logic [2:0] RegAx = 3'd0;
  localparam logic [2:0] RegBx = 3'd3;
  localparam logic [2:0] RegSp = 3'd4;
  localparam logic [2:0] RegBp = 3'd5;
  localparam logic [2:0] RegSi = 3'd6;
  localparam logic [2:0] RegDi = 3'd7;
  localparam logic [1:0] SegCs = 2'd1;
  localparam logic [1:0] SegSs = 2'd2;
  localparam logic [1:0] SegDs = 2'd3;
  localparam logic [3:0] RegSelIp    = 4'd12;
  localparam logic [3:0] RegSelFlags = 4'd13;

  // Reset values
  localparam logic [15:0] ResetCs    = 16'hF000;
  localparam logic [15:0] ResetIp    = 16'hFFF0;
  localparam logic [15:0] ResetFlags = 16'h0002;

  // Opcodes
  localparam logic [7:0] OpNop       = 8'h90;
  localparam logic [7:0] OpHlt       = 8'hF4;
  localparam logic [7:0] OpInt       = 8'hCD;
  localparam logic [7:0] OpMovRi8    = 8'hB0;
  localparam logic [7:0] OpMovRi16   = 8'hB8;
  localparam logic [7:0] OpAddAxi    = 8'h05;
  localparam logic [7:0] OpSubAxi    = 8'h2D;
  localparam logic [7:0] OpCmpAxi    = 8'h3D;
  localparam logic [7:0] OpIncBase   = 8'h40;
  localparam logic [7:0] OpPushBase  = 8'h50;
  localparam logic [7:0] OpPopBase   = 8'h58;
  localparam logic [7:0] OpJmpShort  = 8'hEB;
  localparam logic [7:0] OpJmpNear   = 8'hE9;
  localparam logic [7:0] OpJccBase   = 8'h70;
  localparam logic [7:0] OpJs        = 8'h78;
  localparam logic [7:0] OpMovRmBase = 8'h88;
  localparam logic [7:0] OpMovRmi8   = 8'hC6;
  localparam logic [7:0] OpAddRmR    = 8'h01;
  localparam logic [7:0] OpAddRRm    = 8'h03;
  localparam logic [7:0] OpSubRmR    = 8'h29;
  localparam logic [7:0] OpSubRRm    = 8'h2B;
  localparam logic [7:0] OpCmpRmR    = 8'h39;
  localparam logic [7:0] OpCmpRRm    = 8'h3B;

  typedef enum logic [1:0] {
    ACT_WR   = 2'd0,
    ACT_RD   = 2'd1,
    ACT_STEP = 2'd2,
    ACT_REG  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_HALT   = 2'd1,
    ST_FAULT  = 2'd2,
    ST_UNIMPL = 2'd3
  } run_st_e;

  typedef enum logic [3:0] {
    OC_NOP, OC_HLT, OC_MOV_RI8, OC_MOV_RI16, OC_ALU_AI, OC_INCDEC, OC_PUSH,
    OC_POP, OC_JMP8, OC_JMP16, OC_MOV_RM, OC_MOV_RMI, OC_ALU_RM, OC_INT, OC_BAD
  } op_class_e;

  typedef enum logic [1:0] {
    ADDR_IN, ADDR_CODE, ADDR_EA, ADDR_EA1
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_IN, WD_LO, WD_HI
  } wdata_sel_e;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_RV, CAP_OP, CAP_MODRM, CAP_DISP_LO, CAP_DISP_HI,
    CAP_IMM_LO, CAP_IMM_HI, CAP_OPD_LO, CAP_OPD_HI
  } cap_e;

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT, S_DECODE, S_MODRM, S_DISP_LO, S_DISP_HI, S_EA,
    S_IMM_LO, S_IMM_HI, S_OPD_LO, S_OPD_HI, S_EXEC, S_WR_LO, S_WR_HI, S_RESP
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       mem_rd;
    logic       mem_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    cap_e       cap;
    logic       ip_inc;
    logic       step_inc;
    logic       calc_ea;
    logic       exec;
    logic       set_st;
    run_st_e    st_val;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [7:0] op;
    logic [7:0] modrm;
    run_st_e    run_st;
  } dp_stat_t;

  typedef struct packed {
    logic cf;
    logic pf;
    logic af;
    logic zf;
    logic sf;
    logic of;
  } alu_flags_t;

  // Instruction class of an opcode byte
  function automatic op_class_e op_class(input logic [7:0] op);
    op_class_e c;
    c = OC_BAD;
    if (op == OpNop) c = OC_NOP;
    else if (op == OpHlt) c = OC_HLT;
    else if (op[7:3] == OpMovRi8[7:3]) c = OC_MOV_RI8;
    else if (op[7:3] == OpMovRi16[7:3]) c = OC_MOV_RI16;
    else if (op == OpAddAxi || op == OpSubAxi || op == OpCmpAxi) c = OC_ALU_AI;
    else if (op[7:4] == OpIncBase[7:4]) c = OC_INCDEC;
    else if (op[7:3] == OpPushBase[7:3]) c = OC_PUSH;
    else if (op[7:3] == OpPopBase[7:3]) c = OC_POP;
    else if (op == OpJmpShort) c = OC_JMP8;
    else if (op[7:3] == OpJccBase[7:3] && op[2:1] != 2'b11) c = OC_JMP8;
    else if (op[7:1] == OpJs[7:1]) c = OC_JMP8;
    else if (op == OpJmpNear) c = OC_JMP16;
    else if (op[7:2] == OpMovRmBase[7:2]) c = OC_MOV_RM;
    else if (op[7:1] == OpMovRmi8[7:1]) c = OC_MOV_RMI;
    else if (op == OpAddRmR || op == OpAddRRm || op == OpSubRmR || op == OpSubRRm ||
             op == OpCmpRmR || op == OpCmpRRm) c = OC_ALU_RM;
    else if (op == OpInt) c = OC_INT;
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/x86c_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86_16bit_subset_core
// Small 16-bit x86 core with private byte memory, driven one action at a time.
// ----------------------------------------------------------------------------
// One transaction at a time: an action is taken when the core is idle, and the
// result is held until taken. Memory write and register read go straight to the
// result, memory read through a wait state. An instruction step runs opcode
// fetch, wait, decode and result, plus a read and a wait for each further code
// or data byte (ModRM, displacement, immediate, operand), an effective-address
// step where a ModRM or stack read needs one, a write for each memory byte
// written and an execute step where needed. All fetches and data accesses share
// the single memory port with registered read data. No clearing pass after
// reset: memory holds garbage until loaded.
module x86_16bit_subset_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [3:0]  reg_select_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] read_value_o,
  output logic        int_request_o,
  output logic [7:0]  int_vector_o,
  output logic [7:0]  last_opcode_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  x86c_pkg::dp_cmd_t  cmd;
  x86c_pkg::dp_stat_t stat;

  x86c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  x86c_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .address_i     (address_i),
    .data_byte_i   (data_byte_i),
    .reg_select_i  (reg_select_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .int_request_o (int_request_o),
    .int_vector_o  (int_vector_o),
    .last_opcode_o (last_opcode_o)
  );

  // One transaction in flight: no input taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // A stopped core stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o != x86c_pkg::ST_RUN) |=> (status_o != x86c_pkg::ST_RUN))
    else $error("core left stopped state");

  // Interrupt request only comes from an INT opcode
  a_irq_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int_request_o |-> (last_opcode_o == x86c_pkg::OpInt))
    else $error("interrupt request without INT opcode");

endmodule
`default_nettype wire

FILE: rtl/x86c_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86c_alu
// 16-bit add/subtract unit with x86 arithmetic flags.
// ----------------------------------------------------------------------------
module x86c_alu (
  input  logic [15:0]          a_i,
  input  logic [15:0]          b_i,
  input  logic                 sub_i,
  output logic [15:0]          res_o,
  output x86c_pkg::alu_flags_t flags_o
);

  logic [16:0] sum;

  // Carry/borrow in bit 16
  always_comb begin
    if (sub_i) sum = {1'b0, a_i} - {1'b0, b_i};
    else       sum = {1'b0, a_i} + {1'b0, b_i};
  end

  assign res_o = sum[15:0];

  always_comb begin
    flags_o.cf = sum[16];
    flags_o.pf = ~^sum[7:0];
    flags_o.af = a_i[4] ^ b_i[4] ^ sum[4];
    flags_o.zf = (sum[15:0] == 16'h0000);
    flags_o.sf = sum[15];
    // overflow: operand signs agree (add) or differ (sub), result sign flips
    flags_o.of = (sub_i ? (a_i[15] ^ b_i[15]) : ~(a_i[15] ^ b_i[15])) & (a_i[15] ^ sum[15]);
  end

endmodule
`default_nettype wire

FILE: rtl/x86c_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86c_dpath
// Register file, byte memory, fetch buffers and instruction execution.
// ----------------------------------------------------------------------------
module x86c_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  x86c_pkg::dp_cmd_t   cmd_i,
  output x86c_pkg::dp_stat_t  stat_o,
  input  logic [1:0]          action_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          data_byte_i,
  input  logic [3:0]          reg_select_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output logic [1:0]          status_o,
  output logic [15:0]         read_value_o,
  output logic                int_request_o,
  output logic [7:0]          int_vector_o,
  output logic [7:0]          last_opcode_o
);

  // Architectural state
  logic [15:0] gp_q [8];
  logic [15:0] gp_d [8];
  logic [15:0] seg_q [4];
  logic [15:0] ip_q, ip_d, flags_q, flags_d;
  x86c_pkg::run_st_e st_q, st_d;
  logic [63:0] steps_q, steps_d;
  logic        int_accept_q;

  // Instruction buffers
  logic [7:0]  op_q, op_d, modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d, imm_q, imm_d, opd_q, opd_d, res_q, res_d;
  x86c_pkg::maddr_t ea_q, ea_d;

  // Result registers
  logic [15:0] rv_q, rv_d;
  logic        irq_q, irq_d;
  logic [7:0]  vec_q, vec_d, opc_q, opc_d;

  // Memory port
  logic [7:0]       mem_q [x86c_pkg::MemDepth];
  logic [7:0]       rdata_q, wdata;
  x86c_pkg::maddr_t mem_addr;
  x86c_pkg::cap_e   cap_q;

  // Decode fields
  x86c_pkg::op_class_e cls;
  logic [1:0]  m_mod;
  logic [2:0]  m_reg, m_rm, r_op;
  logic        rm_mem, use_ss, take;
  logic [15:0] rm16, base, reg_read;

  // ALU
  logic [15:0]          alu_a, alu_b, alu_res;
  logic                 alu_sub;
  x86c_pkg::alu_flags_t alu_fl;

  function automatic x86c_pkg::maddr_t lin(input logic [15:0] seg, input logic [15:0] off);
    logic [19:0] s;
    s = {seg, 4'h0} + {4'h0, off};
    return s[x86c_pkg::MemAddrBits-1:0];
  endfunction

  function automatic logic [7:0] get8(input logic [15:0] r [8], input logic [2:0] i);
    return i[2] ? r[{1'b0, i[1:0]}][15:8] : r[{1'b0, i[1:0]}][7:0];
  endfunction

  function automatic logic [15:0] merge_flags(input logic [15:0] f,
                                              input x86c_pkg::alu_flags_t a,
                                              input logic keep_cf);
    logic [15:0] n;
    n = f;
    n[x86c_pkg::FlagCf] = keep_cf ? f[x86c_pkg::FlagCf] : a.cf;
    n[x86c_pkg::FlagPf] = a.pf;
    n[x86c_pkg::FlagAf] = a.af;
    n[x86c_pkg::FlagZf] = a.zf;
    n[x86c_pkg::FlagSf] = a.sf;
    n[x86c_pkg::FlagOf] = a.of;
    return n;
  endfunction

  assign cls    = x86c_pkg::op_class(op_q);
  assign m_mod  = modrm_q[7:6];
  assign m_reg  = modrm_q[5:3];
  assign m_rm   = modrm_q[2:0];
  assign r_op   = op_q[2:0];
  assign rm_mem = (m_mod != 2'b11);
  assign rm16   = rm_mem ? opd_q : gp_q[m_rm];

  // Jcc condition: op[3:1] picks the flag, op[0] inverts
  always_comb begin
    case (op_q[3:1])
      3'b000:  take = flags_q[x86c_pkg::FlagOf];
      3'b001:  take = flags_q[x86c_pkg::FlagCf];
      3'b010:  take = flags_q[x86c_pkg::FlagZf];
      default: take = flags_q[x86c_pkg::FlagSf];
    endcase
    take = (take ^ op_q[0]) | (op_q == x86c_pkg::OpJmpShort);
  end

  // ModRM base register sum and segment choice
  always_comb begin
    case (m_rm)
      3'd0:    base = gp_q[x86c_pkg::RegBx] + gp_q[x86c_pkg::RegSi];
      3'd1:    base = gp_q[x86c_pkg::RegBx] + gp_q[x86c_pkg::RegDi];
      3'd2:    base = gp_q[x86c_pkg::RegBp] + gp_q[x86c_pkg::RegSi];
      3'd3:    base = gp_q[x86c_pkg::RegBp] + gp_q[x86c_pkg::RegDi];
      3'd4:    base = gp_q[x86c_pkg::RegSi];
      3'd5:    base = gp_q[x86c_pkg::RegDi];
      3'd6:    base = (m_mod == 2'b00) ? 16'h0000 : gp_q[x86c_pkg::RegBp];
      default: base = gp_q[x86c_pkg::RegBx];
    endcase
    use_ss = (m_rm == 3'd2) || (m_rm == 3'd3) || (m_rm == 3'd6 && m_mod != 2'b00);
  end

  // Register read for the read-register action
  always_comb begin
    reg_read = 16'h0000;
    if (!reg_select_i[3]) reg_read = gp_q[reg_select_i[2:0]];
    else if (reg_select_i[2] == 1'b0) reg_read = seg_q[reg_select_i[1:0]];
    else if (reg_select_i == x86c_pkg::RegSelIp) reg_read = ip_q;
    else if (reg_select_i == x86c_pkg::RegSelFlags) reg_read = flags_q;
  end

  // ALU operand selection
  always_comb begin
    alu_a   = gp_q[x86c_pkg::RegAx];
    alu_b   = imm_q;
    alu_sub = (op_q != x86c_pkg::OpAddAxi);
    case (cls)
      x86c_pkg::OC_INCDEC: begin
        alu_a   = gp_q[r_op];
        alu_b   = 16'h0001;
        alu_sub = op_q[3];
      end
      x86c_pkg::OC_ALU_RM: begin
        alu_a   = op_q[1] ? gp_q[m_reg] : rm16;
        alu_b   = op_q[1] ? rm16 : gp_q[m_reg];
        alu_sub = op_q[5];
      end
      default: ;
    endcase
  end

  x86c_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .flags_o (alu_fl)
  );

  // Memory address and write data
  always_comb begin
    case (cmd_i.addr_sel)
      x86c_pkg::ADDR_IN:   mem_addr = x86c_pkg::maddr_t'({4'h0, address_i});
      x86c_pkg::ADDR_CODE: mem_addr = lin(seg_q[x86c_pkg::SegCs], ip_q);
      x86c_pkg::ADDR_EA:   mem_addr = ea_q;
      default:             mem_addr = ea_q + x86c_pkg::maddr_t'(1);
    endcase
    case (cmd_i.wdata_sel)
      x86c_pkg::WD_IN: wdata = data_byte_i;
      x86c_pkg::WD_LO: wdata = res_q[7:0];
      default:         wdata = res_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[mem_addr] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= mem_q[mem_addr];
  end

  // Next-state logic for registers and buffers
  always_comb begin
    gp_d    = gp_q;
    ip_d    = ip_q;
    flags_d = flags_q;
    st_d    = st_q;
    steps_d = steps_q;
    op_d    = op_q;
    modrm_d = modrm_q;
    disp_d  = disp_q;
    imm_d   = imm_q;
    opd_d   = opd_q;
    res_d   = res_q;
    ea_d    = ea_q;
    rv_d    = rv_q;
    irq_d   = irq_q;
    vec_d   = vec_q;
    opc_d   = opc_q;

    // new transaction: clear result fields
    if (cmd_i.load_in) begin
      rv_d  = 16'h0000;
      irq_d = 1'b0;
      vec_d = 8'h00;
      opc_d = 8'h00;
      if (action_i == x86c_pkg::ACT_REG) rv_d = reg_read;
    end

    // byte returned by the read issued last cycle
    case (cap_q)
      x86c_pkg::CAP_RV:      rv_d = {8'h00, rdata_q};
      x86c_pkg::CAP_OP: begin
        op_d  = rdata_q;
        opc_d = rdata_q;
      end
      x86c_pkg::CAP_MODRM: begin
        modrm_d = rdata_q;
        disp_d  = 16'h0000;
      end
      x86c_pkg::CAP_DISP_LO:
        disp_d = (m_mod == 2'b01) ? {{8{rdata_q[7]}}, rdata_q} : {8'h00, rdata_q};
      x86c_pkg::CAP_DISP_HI: disp_d[15:8] = rdata_q;
      x86c_pkg::CAP_IMM_LO:  imm_d = {8'h00, rdata_q};
      x86c_pkg::CAP_IMM_HI:  imm_d[15:8] = rdata_q;
      x86c_pkg::CAP_OPD_LO:  opd_d = {8'h00, rdata_q};
      x86c_pkg::CAP_OPD_HI:  opd_d[15:8] = rdata_q;
      default: ;
    endcase

    if (cmd_i.ip_inc)   ip_d    = ip_q + 16'h0001;
    if (cmd_i.step_inc) steps_d = steps_q + 64'd1;
    if (cmd_i.set_st)   st_d    = cmd_i.st_val;

    // effective address: stack top for POP, ModRM otherwise
    if (cmd_i.calc_ea) begin
      if (cls == x86c_pkg::OC_POP)
        ea_d = lin(seg_q[x86c_pkg::SegSs], gp_q[x86c_pkg::RegSp]);
      else
        ea_d = lin(use_ss ? seg_q[x86c_pkg::SegSs] : seg_q[x86c_pkg::SegDs], base + disp_q);
    end

    // execute
    if (cmd_i.exec) begin
      case (cls)
        x86c_pkg::OC_MOV_RI8:
          if (r_op[2]) gp_d[{1'b0, r_op[1:0]}][15:8] = imm_q[7:0];
          else         gp_d[{1'b0, r_op[1:0]}][7:0]  = imm_q[7:0];
        x86c_pkg::OC_MOV_RI16: gp_d[r_op] = imm_q;
        x86c_pkg::OC_ALU_AI: begin
          flags_d = merge_flags(flags_q, alu_fl, 1'b0);
          if (op_q != x86c_pkg::OpCmpAxi) gp_d[x86c_pkg::RegAx] = alu_res;
        end
        x86c_pkg::OC_INCDEC: begin
          gp_d[r_op] = alu_res;
          flags_d    = merge_flags(flags_q, alu_fl, 1'b1);
        end
        x86c_pkg::OC_PUSH: begin
          gp_d[x86c_pkg::RegSp] = gp_q[x86c_pkg::RegSp] - 16'h0002;
          ea_d  = lin(seg_q[x86c_pkg::SegSs], gp_q[x86c_pkg::RegSp] - 16'h0002);
          res_d = (r_op == x86c_pkg::RegSp) ? gp_q[x86c_pkg::RegSp] - 16'h0002 : gp_q[r_op];
        end
        x86c_pkg::OC_POP: begin
          if (r_op == x86c_pkg::RegSp) begin
            gp_d[x86c_pkg::RegSp] = opd_q + 16'h0002;
          end else begin
            gp_d[r_op]            = opd_q;
            gp_d[x86c_pkg::RegSp] = gp_q[x86c_pkg::RegSp] + 16'h0002;
          end
        end
        x86c_pkg::OC_JMP8:
          if (take) ip_d = ip_q + {{8{imm_q[7]}}, imm_q[7:0]};
        x86c_pkg::OC_JMP16: ip_d = ip_q + imm_q;
        x86c_pkg::OC_MOV_RM: begin
          case (op_q[1:0])
            2'b00: begin
              res_d = {8'h00, get8(gp_q, m_reg)};
              if (!rm_mem) begin
                if (m_rm[2]) gp_d[{1'b0, m_rm[1:0]}][15:8] = get8(gp_q, m_reg);
                else         gp_d[{1'b0, m_rm[1:0]}][7:0]  = get8(gp_q, m_reg);
              end
            end
            2'b01: begin
              res_d = gp_q[m_reg];
              if (!rm_mem) gp_d[m_rm] = gp_q[m_reg];
            end
            2'b10: begin
              if (m_reg[2])
                gp_d[{1'b0, m_reg[1:0]}][15:8] = rm_mem ? opd_q[7:0] : get8(gp_q, m_rm);
              else
                gp_d[{1'b0, m_reg[1:0]}][7:0]  = rm_mem ? opd_q[7:0] : get8(gp_q, m_rm);
            end
            default: gp_d[m_reg] = rm16;
          endcase
        end
        x86c_pkg::OC_MOV_RMI: begin
          res_d = op_q[0] ? imm_q : {8'h00, imm_q[7:0]};
          if (!rm_mem) begin
            if (op_q[0])      gp_d[m_rm] = imm_q;
            else if (m_rm[2]) gp_d[{1'b0, m_rm[1:0]}][15:8] = imm_q[7:0];
            else              gp_d[{1'b0, m_rm[1:0]}][7:0]  = imm_q[7:0];
          end
        end
        x86c_pkg::OC_ALU_RM: begin
          flags_d = merge_flags(flags_q, alu_fl, 1'b0);
          res_d   = alu_res;
          // compare forms keep both operands
          if (!(op_q[5] & op_q[4])) begin
            if (op_q[1])      gp_d[m_reg] = alu_res;
            else if (!rm_mem) gp_d[m_rm]  = alu_res;
          end
        end
        x86c_pkg::OC_INT: begin
          irq_d = 1'b1;
          vec_d = imm_q[7:0];
          if (!int_accept_q) st_d = x86c_pkg::ST_UNIMPL;
        end
        default: ;
      endcase
    end
  end

  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gp_q[i] <= 16'h0000;
      for (int i = 0; i < 4; i++) seg_q[i] <= 16'h0000;
      seg_q[x86c_pkg::SegCs] <= x86c_pkg::ResetCs;
      ip_q         <= x86c_pkg::ResetIp;
      flags_q      <= x86c_pkg::ResetFlags;
      st_q         <= x86c_pkg::ST_RUN;
      steps_q      <= 64'd0;
      int_accept_q <= 1'b0;
      cap_q        <= x86c_pkg::CAP_NONE;
      rv_q         <= 16'h0000;
      irq_q        <= 1'b0;
      vec_q        <= 8'h00;
      opc_q        <= 8'h00;
    end else begin
      for (int i = 0; i < 8; i++) gp_q[i] <= gp_d[i];
      ip_q    <= ip_d;
      flags_q <= flags_d;
      st_q    <= st_d;
      steps_q <= steps_d;
      if (cfg_we_i) int_accept_q <= cfg_wdata_i;
      cap_q   <= cmd_i.mem_rd ? cmd_i.cap : x86c_pkg::CAP_NONE;
      rv_q    <= rv_d;
      irq_q   <= irq_d;
      vec_q   <= vec_d;
      opc_q   <= opc_d;
    end
  end

  // Instruction buffers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    modrm_q <= modrm_d;
    disp_q  <= disp_d;
    imm_q   <= imm_d;
    opd_q   <= opd_d;
    res_q   <= res_d;
    ea_q    <= ea_d;
  end

  assign stat_o.op     = op_q;
  assign stat_o.modrm  = modrm_q;
  assign stat_o.run_st = st_q;

  assign status_o      = st_q;
  assign read_value_o  = rv_q;
  assign int_request_o = irq_q;
  assign int_vector_o  = vec_q;
  assign last_opcode_o = opc_q;

endmodule
`default_nettype wire

FILE: rtl/x86c_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86c_ctrl
// Sequencer: handshakes, byte fetch order and execute/write-back steps.
// ----------------------------------------------------------------------------
module x86c_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  x86c_pkg::dp_stat_t stat_i,
  output x86c_pkg::dp_cmd_t  cmd_o
);

  x86c_pkg::ctrl_state_e state_q, state_d, ret_q, ret_d;
  x86c_pkg::op_class_e   cls;
  logic [7:0] op;
  logic [1:0] m_mod;
  logic [2:0] m_rm;
  logic       rm_mem, need_wr, need_opd, opd16, wr16, imm16;
  logic [1:0] disp_n;

  assign op     = stat_i.op;
  assign cls    = x86c_pkg::op_class(op);
  assign m_mod  = stat_i.modrm[7:6];
  assign m_rm   = stat_i.modrm[2:0];
  assign rm_mem = (m_mod != 2'b11);

  // Operand needs of the current instruction
  always_comb begin
    need_wr  = rm_mem & ((cls == x86c_pkg::OC_MOV_RM && !op[1]) ||
                         (cls == x86c_pkg::OC_MOV_RMI) ||
                         (cls == x86c_pkg::OC_ALU_RM && !op[1] && !(op[5] & op[4])));
    need_opd = rm_mem & ((cls == x86c_pkg::OC_MOV_RM && op[1]) ||
                         (cls == x86c_pkg::OC_ALU_RM));
    opd16    = (cls == x86c_pkg::OC_POP) || op[0];
    wr16     = (cls == x86c_pkg::OC_PUSH) || op[0];
    imm16    = (cls == x86c_pkg::OC_MOV_RI16) || (cls == x86c_pkg::OC_ALU_AI) ||
               (cls == x86c_pkg::OC_JMP16) || (cls == x86c_pkg::OC_MOV_RMI && op[0]);
    if (m_mod == 2'b00 && m_rm == 3'd6) disp_n = 2'd2;
    else if (m_mod == 2'b01)           disp_n = 2'd1;
    else if (m_mod == 2'b10)           disp_n = 2'd2;
    else                               disp_n = 2'd0;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= x86c_pkg::S_IDLE;
      ret_q   <= x86c_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      x86c_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (action_i)
            x86c_pkg::ACT_WR: begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.addr_sel  = x86c_pkg::ADDR_IN;
              cmd_o.wdata_sel = x86c_pkg::WD_IN;
              state_d         = x86c_pkg::S_RESP;
            end
            x86c_pkg::ACT_RD: begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = x86c_pkg::ADDR_IN;
              cmd_o.cap      = x86c_pkg::CAP_RV;
              state_d        = x86c_pkg::S_WAIT;
              ret_d          = x86c_pkg::S_RESP;
            end
            x86c_pkg::ACT_STEP: begin
              if (stat_i.run_st != x86c_pkg::ST_RUN) begin
                state_d = x86c_pkg::S_RESP;
              end else begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
                cmd_o.cap      = x86c_pkg::CAP_OP;
                cmd_o.ip_inc   = 1'b1;
                cmd_o.step_inc = 1'b1;
                state_d        = x86c_pkg::S_WAIT;
                ret_d          = x86c_pkg::S_DECODE;
              end
            end
            default: state_d = x86c_pkg::S_RESP;
          endcase
        end
      end
      // memory byte lands in its buffer
      x86c_pkg::S_WAIT: state_d = ret_q;
      x86c_pkg::S_DECODE: begin
        case (cls)
          x86c_pkg::OC_NOP: state_d = x86c_pkg::S_RESP;
          x86c_pkg::OC_HLT: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st_val = x86c_pkg::ST_HALT;
            state_d      = x86c_pkg::S_RESP;
          end
          x86c_pkg::OC_INCDEC, x86c_pkg::OC_PUSH: state_d = x86c_pkg::S_EXEC;
          x86c_pkg::OC_POP: state_d = x86c_pkg::S_EA;
          x86c_pkg::OC_MOV_RM, x86c_pkg::OC_MOV_RMI, x86c_pkg::OC_ALU_RM:
            state_d = x86c_pkg::S_MODRM;
          x86c_pkg::OC_MOV_RI8, x86c_pkg::OC_MOV_RI16, x86c_pkg::OC_ALU_AI,
          x86c_pkg::OC_JMP8, x86c_pkg::OC_JMP16, x86c_pkg::OC_INT:
            state_d = x86c_pkg::S_IMM_LO;
          default: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st_val = x86c_pkg::ST_UNIMPL;
            state_d      = x86c_pkg::S_RESP;
          end
        endcase
      end
      x86c_pkg::S_MODRM: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
        cmd_o.cap      = x86c_pkg::CAP_MODRM;
        cmd_o.ip_inc   = 1'b1;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = x86c_pkg::S_DISP_LO;
      end
      x86c_pkg::S_DISP_LO: begin
        if (disp_n == 2'd0) begin
          state_d = x86c_pkg::S_EA;
        end else begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
          cmd_o.cap      = x86c_pkg::CAP_DISP_LO;
          cmd_o.ip_inc   = 1'b1;
          state_d        = x86c_pkg::S_WAIT;
          ret_d          = (disp_n == 2'd2) ? x86c_pkg::S_DISP_HI : x86c_pkg::S_EA;
        end
      end
      x86c_pkg::S_DISP_HI: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
        cmd_o.cap      = x86c_pkg::CAP_DISP_HI;
        cmd_o.ip_inc   = 1'b1;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = x86c_pkg::S_EA;
      end
      x86c_pkg::S_EA: begin
        cmd_o.calc_ea = 1'b1;
        if (cls == x86c_pkg::OC_POP) begin
          state_d = x86c_pkg::S_OPD_LO;
        end else if (cls == x86c_pkg::OC_MOV_RMI) begin
          // immediate store with a nonzero group field faults
          if (stat_i.modrm[5:3] != 3'd0) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st_val = x86c_pkg::ST_FAULT;
            state_d      = x86c_pkg::S_RESP;
          end else begin
            state_d = x86c_pkg::S_IMM_LO;
          end
        end else if (need_opd) begin
          state_d = x86c_pkg::S_OPD_LO;
        end else begin
          state_d = x86c_pkg::S_EXEC;
        end
      end
      x86c_pkg::S_IMM_LO: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
        cmd_o.cap      = x86c_pkg::CAP_IMM_LO;
        cmd_o.ip_inc   = 1'b1;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = imm16 ? x86c_pkg::S_IMM_HI : x86c_pkg::S_EXEC;
      end
      x86c_pkg::S_IMM_HI: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_CODE;
        cmd_o.cap      = x86c_pkg::CAP_IMM_HI;
        cmd_o.ip_inc   = 1'b1;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = x86c_pkg::S_EXEC;
      end
      x86c_pkg::S_OPD_LO: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_EA;
        cmd_o.cap      = x86c_pkg::CAP_OPD_LO;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = opd16 ? x86c_pkg::S_OPD_HI : x86c_pkg::S_EXEC;
      end
      x86c_pkg::S_OPD_HI: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = x86c_pkg::ADDR_EA1;
        cmd_o.cap      = x86c_pkg::CAP_OPD_HI;
        state_d        = x86c_pkg::S_WAIT;
        ret_d          = x86c_pkg::S_EXEC;
      end
      x86c_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (cls == x86c_pkg::OC_PUSH || need_wr) state_d = x86c_pkg::S_WR_LO;
        else                                    state_d = x86c_pkg::S_RESP;
      end
      x86c_pkg::S_WR_LO: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = x86c_pkg::ADDR_EA;
        cmd_o.wdata_sel = x86c_pkg::WD_LO;
        state_d         = wr16 ? x86c_pkg::S_WR_HI : x86c_pkg::S_RESP;
      end
      x86c_pkg::S_WR_HI: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = x86c_pkg::ADDR_EA1;
        cmd_o.wdata_sel = x86c_pkg::WD_HI;
        state_d         = x86c_pkg::S_RESP;
      end
      x86c_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = x86c_pkg::S_IDLE;
      end
      default: state_d = x86c_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire
